@@ hw/rtl/cramer_solve_3x3_assert.svh @@
// Assertion macros used by the checker file.
`ifndef CRAMER_SOLVE_3X3_ASSERT_SVH
`define CRAMER_SOLVE_3X3_ASSERT_SVH
// Assert that an antecedent implies a consequent on the next edge.
`define CS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
// Assert that a condition holds at every edge.
`define CS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);
`endif

@@ hw/rtl/cs3_pkg.sv @@
// Package: widths and shared types for the 3x3 Cramer solver.
package cs3_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DW = 32;
    localparam int PW = 64;
    localparam int SW = 99;
    localparam int QDEPTH = 4;
    localparam int QAW = 2;
    localparam int NUM_DW = 124;

    typedef struct packed {
        logic signed [SW-1:0] d;
        logic signed [SW-1:0] nx;
        logic signed [SW-1:0] ny;
        logic signed [SW-1:0] nz;
    } cs3_dets_t;
endpackage

@@ hw/rtl/cs3_front.sv @@
// Front end: pipelined determinant and numerator evaluation.
module cs3_front (
    input  logic clk,
    input  logic rst_n,
    input  logic in_vld,
    input  logic signed [31:0] a0, a1, a2, b0, b1, b2, c0, c1, c2, r0, r1, r2,
    output logic out_vld,
    output cs3_pkg::cs3_dets_t out_dets
);
    localparam int PW = cs3_pkg::PW;
    localparam int SW = cs3_pkg::SW;

    // stage 1: pairwise products (24 terms)
    logic signed [PW-1:0] p_reg [0:23];
    logic signed [31:0]   t_reg [0:23];
    logic signed [PW-1:0] p_next [0:23];
    logic signed [31:0]   t_next [0:23];
    logic [3:0] vld_reg;
    // stage 2: low and high partials of each triple product
    logic signed [64:0] lo_reg [0:23];
    logic signed [63:0] hi_reg [0:23];
    // stage 3 triple products
    logic signed [96:0] tp_reg [0:23];
    cs3_pkg::cs3_dets_t dets_reg, dets_next;
    logic signed [31:0] m [0:3][0:8];

    // build the four matrices: D, and each with a column replaced by rhs
    always_comb
    begin
        m[0] = '{a0, a1, a2, b0, b1, b2, c0, c1, c2};
        m[1] = '{r0, r1, r2, b0, b1, b2, c0, c1, c2};
        m[2] = '{a0, a1, a2, r0, r1, r2, c0, c1, c2};
        m[3] = '{a0, a1, a2, b0, b1, b2, r0, r1, r2};
        for (int k = 0; k < 4; k++)
        begin
            p_next[6*k+0] = PW'(m[k][0]) * PW'(m[k][4]); t_next[6*k+0] = m[k][8];
            p_next[6*k+1] = PW'(m[k][3]) * PW'(m[k][7]); t_next[6*k+1] = m[k][2];
            p_next[6*k+2] = PW'(m[k][6]) * PW'(m[k][1]); t_next[6*k+2] = m[k][5];
            p_next[6*k+3] = PW'(m[k][0]) * PW'(m[k][7]); t_next[6*k+3] = m[k][5];
            p_next[6*k+4] = PW'(m[k][3]) * PW'(m[k][1]); t_next[6*k+4] = m[k][8];
            p_next[6*k+5] = PW'(m[k][6]) * PW'(m[k][4]); t_next[6*k+5] = m[k][2];
        end
    end

    // sum six signed terms per determinant
    always_comb
    begin
        logic signed [SW-1:0] s [0:3];
        for (int k = 0; k < 4; k++)
            s[k] = SW'(tp_reg[6*k]) + SW'(tp_reg[6*k+1]) + SW'(tp_reg[6*k+2])
                 - SW'(tp_reg[6*k+3]) - SW'(tp_reg[6*k+4]) - SW'(tp_reg[6*k+5]);
        dets_next = '{d: s[0], nx: s[1], ny: s[2], nz: s[3]};
    end

    // advance the product pipeline; split each 64x32 product into two halves
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 24; i++)
        begin
            p_reg[i]  <= p_next[i];
            t_reg[i]  <= t_next[i];
            lo_reg[i] <= 65'($signed({1'b0, p_reg[i][31:0]})) * 65'(t_reg[i]);
            hi_reg[i] <= 64'($signed(p_reg[i][63:32])) * 64'(t_reg[i]);
            tp_reg[i] <= (97'(hi_reg[i]) <<< 32) + 97'(lo_reg[i]);
        end
        dets_reg <= dets_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[2:0], in_vld};
    end

    assign out_vld  = vld_reg[3];
    assign out_dets = dets_reg;
endmodule

@@ hw/rtl/cs3_queue.sv @@
// Short FIFO of determinant sets between front and back ends.
module cs3_queue (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cs3_pkg::cs3_dets_t wdata,
    input  logic pop,
    output logic nempty,
    output cs3_pkg::cs3_dets_t rdata
);
    localparam int AW = cs3_pkg::QAW;
    cs3_pkg::cs3_dets_t mem_reg [0:cs3_pkg::QDEPTH-1];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;

    // write the incoming beat
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wdata;
    end

    // advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    assign nempty = (cnt_reg != '0);
    assign rdata  = mem_reg[rp_reg];
endmodule

@@ hw/rtl/cs3_back.sv @@
// Back end: pipelined restoring division, one quotient bit per stage.
module cs3_back #(
    parameter int FRAC_BITS = cs3_pkg::FRAC_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_vld,
    input  cs3_pkg::cs3_dets_t in_dets,
    output logic out_vld,
    output logic signed [31:0] sol_x,
    output logic signed [31:0] sol_y,
    output logic signed [31:0] sol_z,
    output logic singular
);
    localparam int SW = cs3_pkg::SW;
    localparam int MW = SW - 1;
    // quotient needs 33 bits plus one overflow guard
    localparam int QB = 34;
    localparam int NST = QB;
    // numerator magnitude scaled, bits above QB in the quotient mean overflow
    localparam int NW = MW + FRAC_BITS;

    typedef struct packed {
        logic [MW-1:0]       dm;
        logic [2:0][NW-1:0]  num;
        logic [2:0][MW:0]    rem;
        logic [2:0][QB-1:0]  q;
        logic [2:0]          neg;
        logic [2:0]          ovf;
        logic                sing;
    } stg_t;

    stg_t st_reg [0:NST];
    stg_t st_next [0:NST];
    logic [NST:0] v_reg;
    stg_t s0;

    // take magnitudes and signs
    always_comb
    begin
        logic signed [SW-1:0] n [0:2];
        logic [MW-1:0] nm;
        n[0] = in_dets.nx; n[1] = in_dets.ny; n[2] = in_dets.nz;
        s0 = '0;
        s0.dm = in_dets.d[SW-1] ? MW'(-in_dets.d) : MW'(in_dets.d);
        s0.sing = (in_dets.d == '0);
        for (int k = 0; k < 3; k++)
        begin
            nm = n[k][SW-1] ? MW'(-n[k]) : MW'(n[k]);
            s0.num[k] = {nm, {FRAC_BITS{1'b0}}};
            s0.neg[k] = n[k][SW-1] ^ in_dets.d[SW-1];
            // quotient too big if num >= dm << QB
            s0.ovf[k] = ((NW+QB)'(nm) << FRAC_BITS) >= ((NW+QB)'(s0.dm) << QB);
            // prime remainder with high bits above quotient range
            s0.rem[k] = (MW+1)'(s0.num[k] >> QB);
            s0.num[k] = s0.num[k] << (NW - QB);
        end
    end

    // one restoring step per stage
    always_comb
    begin
        logic [MW+1:0] tr;
        tr = '0;
        st_next[0] = s0;
        for (int i = 0; i < NST; i++)
        begin
            st_next[i+1] = st_reg[i];
            for (int k = 0; k < 3; k++)
            begin
                tr = {st_reg[i].rem[k], st_reg[i].num[k][NW-1]};
                st_next[i+1].num[k] = st_reg[i].num[k] << 1;
                if (tr >= {2'b0, st_reg[i].dm})
                begin
                    st_next[i+1].rem[k] = (MW+1)'(tr - {2'b0, st_reg[i].dm});
                    st_next[i+1].q[k]   = {st_reg[i].q[k][QB-2:0], 1'b1};
                end
                else
                begin
                    st_next[i+1].rem[k] = tr[MW:0];
                    st_next[i+1].q[k]   = {st_reg[i].q[k][QB-2:0], 1'b0};
                end
            end
        end
    end

    // advance the divider stages
    always_ff @(posedge clk)
    begin
        for (int i = 0; i <= NST; i++)
            st_reg[i] <= st_next[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[NST-1:0], in_vld};
    end

    // zero the quotients when singular, else saturate and sign them
    function automatic logic [31:0] fin(input logic [QB-1:0] q, input logic ng,
                                        input logic ov, input logic sg);
        logic [31:0] r;
        if (sg)
            r = '0;
        else if (ng)
            r = (ov || q > QB'(33'h080000000)) ? 32'h80000000 : 32'(-q);
        else
            r = (ov || q > QB'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : q[31:0];
        return r;
    endfunction

    assign out_vld  = v_reg[NST];
    assign sol_x    = fin(st_reg[NST].q[0], st_reg[NST].neg[0], st_reg[NST].ovf[0],
                          st_reg[NST].sing);
    assign sol_y    = fin(st_reg[NST].q[1], st_reg[NST].neg[1], st_reg[NST].ovf[1],
                          st_reg[NST].sing);
    assign sol_z    = fin(st_reg[NST].q[2], st_reg[NST].neg[2], st_reg[NST].ovf[2],
                          st_reg[NST].sing);
    assign singular = st_reg[NST].sing;
endmodule

@@ hw/rtl/cramer_solve_3x3.sv @@
// Top level: 3x3 linear solve by Cramer's rule, streaming one system per cycle.
// A system is taken on any cycle where start is high; busy stays low, so one
// item enters per clock. From the accepting edge to the edge that takes the
// result, a system passes through four front stages (pair products, split
// triple-product partials, triple products, determinant sums), the queue,
// one magnitude stage, then one divider stage per quotient bit (34 stages).
// Each result shows for one cycle with done high and cannot be held off.
module cramer_solve_3x3 #(
    parameter int FRAC_BITS = cs3_pkg::FRAC_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  logic signed [31:0] first_x, first_y, first_z,
    input  logic signed [31:0] second_x, second_y, second_z,
    input  logic signed [31:0] third_x, third_y, third_z,
    input  logic signed [31:0] rhs_x, rhs_y, rhs_z,
    output logic done,
    output logic signed [31:0] sol_x,
    output logic signed [31:0] sol_y,
    output logic signed [31:0] sol_z,
    output logic singular
);
    logic f_vld, q_ne;
    cs3_pkg::cs3_dets_t f_dets, q_dets;

    assign busy = 1'b0;

    cs3_front u_front (
        .clk, .rst_n, .in_vld(start),
        .a0(first_x), .a1(first_y), .a2(first_z),
        .b0(second_x), .b1(second_y), .b2(second_z),
        .c0(third_x), .c1(third_y), .c2(third_z),
        .r0(rhs_x), .r1(rhs_y), .r2(rhs_z),
        .out_vld(f_vld), .out_dets(f_dets)
    );

    cs3_queue u_queue (
        .clk, .rst_n, .push(f_vld), .wdata(f_dets),
        .pop(q_ne), .nempty(q_ne), .rdata(q_dets)
    );

    cs3_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk, .rst_n, .in_vld(q_ne), .in_dets(q_dets),
        .out_vld(done), .sol_x, .sol_y, .sol_z, .singular
    );
endmodule

@@ hw/rtl/cs3_checker.sv @@
// Port-level checker for the Cramer solver, bound to the top level.
`include "cramer_solve_3x3_assert.svh"
module cs3_checker (
    input logic clk,
    input logic rst_n,
    input logic busy,
    input logic done,
    input logic singular,
    input logic signed [31:0] sol_x,
    input logic signed [31:0] sol_y,
    input logic signed [31:0] sol_z
);
    `CS_ASSERT_ALWAYS(a_sing_zero, clk, rst_n,
        !(done && singular) || (sol_x == 0 && sol_y == 0 && sol_z == 0),
        "singular result not zero")
    `CS_ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy, "busy raised")
    `CS_ASSERT_NEXT(a_reset_quiet, clk, rst_n, !$past(rst_n), !done,
        "done right after reset")
endmodule

bind cramer_solve_3x3 cs3_checker u_chk (.*);

@@ bench/testbench.sv @@
// Testbench for cramer_solve_3x3: directed table plus random systems, checked by a predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = cs3_pkg::FRAC_BITS_DEF;
    localparam int N_RANDOM = 1730;
    localparam int STALL_LIMIT = 2000;
    localparam logic signed [31:0] SAT_POS = 32'sh7fffffff;
    localparam logic signed [31:0] SAT_NEG = 32'sh80000000;
    localparam logic signed [31:0] ONE = 32'sh00010000;

    typedef struct {
        logic signed [31:0] m [9];
        logic signed [31:0] b [3];
    } system_t;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               sing;
    } solution_t;

    typedef struct {
        system_t   sys;
        bit        typed;
        solution_t sol;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [31:0] first_x = '0, first_y = '0, first_z = '0;
    logic signed [31:0] second_x = '0, second_y = '0, second_z = '0;
    logic signed [31:0] third_x = '0, third_y = '0, third_z = '0;
    logic signed [31:0] rhs_x = '0, rhs_y = '0, rhs_z = '0;
    logic done;
    logic signed [31:0] sol_x, sol_y, sol_z;
    logic singular;

    solution_t pending_solutions[$];
    row_t      directed_rows[$];
    int        fail_count = 0;
    int        idle_cycles = 0;
    int        solved_count = 0;
    int        singular_count = 0;
    int        saturated_count = 0;
    bit        quiet_stretch = 1'b0;

    cramer_solve_3x3 u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .first_x(first_x), .first_y(first_y), .first_z(first_z),
        .second_x(second_x), .second_y(second_y), .second_z(second_z),
        .third_x(third_x), .third_y(third_y), .third_z(third_z),
        .rhs_x(rhs_x), .rhs_y(rhs_y), .rhs_z(rhs_z),
        .done(done), .sol_x(sol_x), .sol_y(sol_y), .sol_z(sol_z),
        .singular(singular)
    );

    always #6 clk = ~clk;

    // Determinant of the matrix with columns p, q, s, held exactly
    function automatic logic signed [127:0] det3(
        input logic signed [31:0] p [3], input logic signed [31:0] q [3],
        input logic signed [31:0] s [3]
    );
        logic signed [127:0] acc;
        acc = 128'(p[0]) * q[1] * s[2] + 128'(q[0]) * s[1] * p[2]
            + 128'(s[0]) * p[1] * q[2] - 128'(p[0]) * s[1] * q[2]
            - 128'(q[0]) * p[1] * s[2] - 128'(s[0]) * q[1] * p[2];
        return acc;
    endfunction

    // Scaled quotient, truncated toward zero, saturated to 32 bits
    function automatic logic signed [31:0] scaled_quotient(
        input logic signed [127:0] num, input logic signed [127:0] den
    );
        logic [127:0] un, ud, uq;
        logic neg;
        neg = num[127] ^ den[127];
        un = num[127] ? -num : num;
        ud = den[127] ? -den : den;
        uq = (un << FRAC) / ud;
        if (neg)
            return (uq > 128'h80000000) ? SAT_NEG : -uq[31:0];
        return (uq > 128'h7fffffff) ? SAT_POS : uq[31:0];
    endfunction

    function automatic solution_t solve_system(input system_t s);
        logic signed [31:0] c0 [3], c1 [3], c2 [3], r [3];
        logic signed [127:0] d;
        solution_t sol;
        for (int i = 0; i < 3; i++)
        begin
            c0[i] = s.m[i];
            c1[i] = s.m[3 + i];
            c2[i] = s.m[6 + i];
            r[i] = s.b[i];
        end
        d = det3(c0, c1, c2);
        if (d == 0)
        begin
            sol = '{x: 0, y: 0, z: 0, sing: 1'b1};
            return sol;
        end
        sol.x = scaled_quotient(det3(r, c1, c2), d);
        sol.y = scaled_quotient(det3(c0, r, c2), d);
        sol.z = scaled_quotient(det3(c0, c1, r), d);
        sol.sing = 1'b0;
        return sol;
    endfunction

    function automatic logic signed [31:0] rand_entry(input int mode);
        case (mode)
            0: return $urandom();
            1: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
            2: return ($urandom_range(0, 1) ? SAT_POS : SAT_NEG);
            default: return $signed($urandom_range(0, 8) - 4) <<< FRAC;
        endcase
    endfunction

    function automatic system_t rand_system();
        system_t s;
        int mode;
        mode = $urandom_range(0, 9);
        if (mode > 3)
            mode = (mode < 7) ? 1 : 0;
        for (int i = 0; i < 9; i++)
            s.m[i] = rand_entry($urandom_range(0, 15) == 0 ? 2 : mode);
        for (int i = 0; i < 3; i++)
            s.b[i] = rand_entry($urandom_range(0, 15) == 0 ? 2 : mode);
        // Force a repeated column now and then to hit a zero determinant
        if ($urandom_range(0, 19) == 0)
            for (int i = 0; i < 3; i++)
                s.m[6 + i] = s.m[i];
        return s;
    endfunction

    function automatic system_t make_system(
        input logic signed [31:0] a0, a1, a2, a3, a4, a5, a6, a7, a8,
        input logic signed [31:0] b0, b1, b2
    );
        system_t s;
        s.m = '{a0, a1, a2, a3, a4, a5, a6, a7, a8};
        s.b = '{b0, b1, b2};
        return s;
    endfunction

    function automatic void add_row(input system_t s, input bit typed, input solution_t sol);
        row_t r;
        r.sys = s;
        r.typed = typed;
        r.sol = sol;
        directed_rows.push_back(r);
    endfunction

    // Drive one system and hold start until the beat is taken
    task automatic send_system(input system_t s, input solution_t expected);
        while (!quiet_stretch && $urandom_range(0, 99) < 6)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        {first_x, first_y, first_z} <= {s.m[0], s.m[1], s.m[2]};
        {second_x, second_y, second_z} <= {s.m[3], s.m[4], s.m[5]};
        {third_x, third_y, third_z} <= {s.m[6], s.m[7], s.m[8]};
        {rhs_x, rhs_y, rhs_z} <= {s.b[0], s.b[1], s.b[2]};
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_solutions.push_back(expected);
        if (expected.sing)
            singular_count++;
        if (expected.x inside {SAT_POS, SAT_NEG})
            saturated_count++;
        @(negedge clk);
    endtask

    // Check each result beat against the oldest expectation
    always @(posedge clk)
    begin
        solution_t e;
        if (rst_n && done)
        begin
            if (pending_solutions.size() == 0)
            begin
                $error("result beat with no expectation waiting");
                fail_count++;
            end
            else
            begin
                e = pending_solutions.pop_front();
                solved_count++;
                if (sol_x !== e.x)
                begin
                    $error("sol_x expected %0d actual %0d", e.x, sol_x);
                    fail_count++;
                end
                if (sol_y !== e.y)
                begin
                    $error("sol_y expected %0d actual %0d", e.y, sol_y);
                    fail_count++;
                end
                if (sol_z !== e.z)
                begin
                    $error("sol_z expected %0d actual %0d", e.z, sol_z);
                    fail_count++;
                end
                if (singular !== e.sing)
                begin
                    $error("singular expected %0b actual %0b", e.sing, singular);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: count cycles with no beat moving either way
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("cramer_solve_3x3 test failed");
            $finish;
        end
    end

    initial
    begin
        system_t s;
        solution_t e;
        solution_t zero_sing;
        solution_t dummy;
        zero_sing = '{x: 0, y: 0, z: 0, sing: 1'b1};
        dummy = zero_sing;

        // Directed rows: expectations typed where obvious
        add_row(make_system(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, zero_sing);
        add_row(make_system(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 3 * ONE, -ONE, 7),
                1, '{x: 3 * ONE, y: -ONE, z: 7, sing: 1'b0});
        add_row(make_system(SAT_NEG, SAT_NEG, SAT_NEG, SAT_NEG, SAT_NEG, SAT_NEG,
                            SAT_POS, SAT_POS, SAT_POS, 1, 2, 3), 1, zero_sing);
        add_row(make_system(1, 0, 0, 0, 1, 0, 0, 0, 1, SAT_POS, SAT_NEG, 1),
                1, '{x: SAT_POS, y: SAT_NEG, z: ONE, sing: 1'b0});
        add_row(make_system(-1, 0, 0, 0, -1, 0, 0, 0, -1, SAT_POS, SAT_NEG, -1),
                1, '{x: SAT_NEG, y: SAT_POS, z: ONE, sing: 1'b0});
        add_row(make_system(SAT_POS, 0, 0, 0, SAT_POS, 0, 0, 0, SAT_POS, 0, 0, 0),
                1, '{x: 0, y: 0, z: 0, sing: 1'b0});
        add_row(make_system(SAT_NEG, 0, 0, 0, SAT_NEG, 0, 0, 0, SAT_NEG,
                            SAT_NEG, SAT_POS, -1), 0, dummy);
        add_row(make_system(SAT_POS, SAT_NEG, 5, SAT_NEG, SAT_POS, -7, 3, 9, SAT_NEG,
                            SAT_POS, SAT_POS, SAT_NEG), 0, dummy);
        add_row(make_system(2 * ONE, ONE, 0, ONE, 3 * ONE, ONE, 0, ONE, 4 * ONE,
                            ONE, 2 * ONE, 3 * ONE), 0, dummy);
        add_row(make_system(3 * ONE, 0, 0, 0, 3 * ONE, 0, 0, 0, 3 * ONE,
                            ONE, -ONE, 2), 0, dummy);
        add_row(make_system(32'shffffffff, 1, 1, 1, 32'shffffffff, 1, 1, 1,
                            32'shffffffff, -1, -1, -1), 0, dummy);
        add_row(make_system(ONE, 2 * ONE, 3 * ONE, 2 * ONE, 4 * ONE, 6 * ONE,
                            ONE, 0, ONE, 5, 6, 7), 1, zero_sing);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            e = solve_system(directed_rows[i].sys);
            if (directed_rows[i].typed &&
                (e.x != directed_rows[i].sol.x || e.y != directed_rows[i].sol.y ||
                 e.z != directed_rows[i].sol.z || e.sing != directed_rows[i].sol.sing))
            begin
                $error("directed row %0d: predictor disagrees with typed result", i);
                fail_count++;
            end
            send_system(directed_rows[i].sys, directed_rows[i].typed ?
                        directed_rows[i].sol : e);
        end
        start <= 1'b0;

        // Hold off until the pipe drains once
        while (pending_solutions.size() != 0)
            @(negedge clk);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            quiet_stretch = (n >= 600 && n < 900);
            s = rand_system();
            send_system(s, solve_system(s));
        end
        start <= 1'b0;

        while (pending_solutions.size() != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);

        $display("Solved %0d systems: %0d singular, %0d with saturated x.",
                 solved_count, singular_count, saturated_count);
        if (fail_count == 0)
            $display("cramer_solve_3x3 test passed");
        else
            $display("cramer_solve_3x3 test failed");
        $finish;
    end
endmodule
